// ===== sv/nsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_pkg: shared types and constants of the sentence checksum framer
// Character codes, phase codes, the length limit and the result word layout.
// ----------------------------------------------------------------------------
package nsc_pkg;

  localparam int MAX_LEN = 1023;
  localparam int COUNT_W = 10;
  localparam int COUNT_CAP = (1 << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] LEN_LIMIT =
    COUNT_W'((MAX_LEN < COUNT_CAP) ? MAX_LEN : COUNT_CAP);

  // character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  // framer phases
  localparam logic [1:0] PH_OUTSIDE = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_HIGH    = 2'd2;
  localparam logic [1:0] PH_LOW     = 2'd3;

  typedef struct packed {
    logic               is_end;
    logic [7:0]         data;
    logic [7:0]         residual;
    logic               checksum_ok;
    logic [COUNT_W-1:0] length;
    logic               overflow;
    logic               bad_hex;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] nib;
  } hex_digit_t;

  // Decode one hex character; a non-hex character gives nibble 0, not valid.
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.valid = 1'b1;
    d.nib   = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      d.nib = 4'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LF) begin
      d.nib = 4'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UF) begin
      d.nib = 4'(c - CH_UA + 8'd10);
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

// ===== sv/nsc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_in_if / nsc_out_if: valid/ready channels of the framer
// One received character in, one payload byte or end report out.
// ----------------------------------------------------------------------------
interface nsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsc_out_if;
  logic       valid;
  logic       ready;
  logic       is_end;
  logic [7:0] data;
  logic [7:0] residual;
  logic       checksum_ok;
  logic [9:0] length;
  logic       overflow;
  logic       bad_hex;

  modport source (output valid, output is_end, output data, output residual,
                  output checksum_ok, output length, output overflow,
                  output bad_hex, input ready);
  modport sink   (input valid, input is_end, input data, input residual,
                  input checksum_ok, input length, input overflow,
                  input bad_hex, output ready);
endinterface

// ===== sv/nmea_sentence_checksum_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_framer: NMEA 0183 sentence framer with checksum
// Forwards payload bytes and emits one end report per sentence.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  carries one received character per word (rx_byte).
//   out_bus carries a payload byte (is_end = 0) or an end-of-sentence report
//   (is_end = 1) with residual, checksum_ok, length, overflow and bad_hex.
//   Characters outside a sentence, the '$' opener, the '*' and the first
//   checksum digit produce no output word.
// Timing:
//   One character per cycle sustained unless out_bus stalls. An accepted
//   word sits in the input register, is processed by the framer logic and,
//   if it makes an output word, is loaded into the output register.
// Reset:
//   rst_n (synchronous, active low) empties both registers and returns the
//   framer to waiting for '$'.
// Stall:
//   While out_bus.ready is low a pending result is held; the input register
//   still drains characters that make no output, and in_bus.ready drops only
//   when the held character would produce a word that has nowhere to go.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_framer (
  input  logic             clk,
  input  logic             rst_n,
  nsc_in_if.sink           in_bus,
  nsc_out_if.source        out_bus
);
  import nsc_pkg::*;

  logic       stg_vld;
  logic [7:0] stg_byte;
  logic       take;
  logic       has_res;
  result_t    res;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;
  logic       load;

  nsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .in_byte  (in_bus.rx_byte),
    .take     (take),
    .vld_r    (stg_vld),
    .byte_r   (stg_byte)
  );

  nsc_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (take),
    .rx_byte (stg_byte),
    .has_res (has_res),
    .res     (res)
  );

  // consume the staged word unless its result has no free slot
  assign take = stg_vld && (!has_res || !out_valid_r || out_bus.ready);
  assign load = take && has_res;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the result word
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.is_end      = out_r.is_end;
  assign out_bus.data        = out_r.data;
  assign out_bus.residual    = out_r.residual;
  assign out_bus.checksum_ok = out_r.checksum_ok;
  assign out_bus.length      = out_r.length;
  assign out_bus.overflow    = out_r.overflow;
  assign out_bus.bad_hex     = out_r.bad_hex;
endmodule

// ===== sv/nsc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_front: input register of the framer
// Holds one received word until the framer stage consumes it.
// ----------------------------------------------------------------------------
module nsc_front (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       vld_r,
  output logic [7:0] byte_r
);
  logic vld_nxt;

  // accept a new word when empty or when the held word leaves this cycle
  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // hold the received character
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end
endmodule

// ===== sv/nsc_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_framer: sentence state and checksum accumulation
// One step per character: phase tracking, XOR checksum, length count and
// the result word for payload bytes and end reports.
// ----------------------------------------------------------------------------
module nsc_framer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  output logic            has_res,
  output nsc_pkg::result_t res
);
  import nsc_pkg::*;

  logic [1:0]         phase_r, phase_nxt;
  logic [7:0]         acc_r, acc_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic               bad_r, bad_nxt;
  hex_digit_t         hx;

  assign hx = hex_decode(rx_byte);

  // next state and result of one character
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    bad_nxt   = bad_r;
    has_res   = 1'b0;
    res       = '0;
    case (phase_r)
      PH_OUTSIDE: begin
        if (rx_byte == CH_DOLLAR) begin
          acc_nxt   = '0;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          bad_nxt   = 1'b0;
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (rx_byte == CH_STAR) begin
          phase_nxt = PH_HIGH;
        end else begin
          acc_nxt = acc_r ^ rx_byte;
          // drop bytes past the limit, but keep them in the checksum
          if (count_r >= LEN_LIMIT) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
            has_res   = 1'b1;
            res.data  = rx_byte;
          end
        end
      end
      PH_HIGH: begin
        bad_nxt   = bad_r | !hx.valid;
        acc_nxt   = acc_r ^ {hx.nib, 4'b0000};
        phase_nxt = PH_LOW;
      end
      PH_LOW: begin
        bad_nxt         = bad_r | !hx.valid;
        acc_nxt         = acc_r ^ {4'b0000, hx.nib};
        phase_nxt       = PH_OUTSIDE;
        has_res         = 1'b1;
        res.is_end      = 1'b1;
        res.residual    = acc_nxt;
        res.checksum_ok = (acc_nxt == 8'd0) && !bad_nxt && !ovf_r;
        res.length      = count_r;
        res.overflow    = ovf_r;
        res.bad_hex     = bad_nxt;
      end
      default: begin
        phase_nxt = PH_OUTSIDE;
      end
    endcase
  end

  // advance the state on each consumed character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OUTSIDE;
      acc_r   <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
      bad_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      bad_r   <= bad_nxt;
    end
  end
endmodule

// ===== tb/tb_nmea_sentence_checksum_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nmea_sentence_checksum_framer: self-checking bench for the sentence framer
// Feeds a character stream of hand-built and random sentences (good and bad
// checksums, bad hex digits, truncated frames, noise, over-long payloads),
// predicts every payload word and end report, and checks them in order.
// Sender gaps and receiver stalls vary phase by phase.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_checksum_framer;
  import nsc_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int DIRECTED_LEN  = 24;
  localparam int SEGMENT_CHARS = 200;
  localparam int MAX_REPORTS   = 10;

  // idle modes of the two channel ends
  localparam logic [1:0] IDLE_NONE   = 2'd0;
  localparam logic [1:0] IDLE_SENDER = 2'd1;
  localparam logic [1:0] IDLE_RECV   = 2'd2;
  localparam logic [1:0] IDLE_BOTH   = 2'd3;

  logic clk;
  logic rst_n;
  logic draining;
  logic [1:0] idle_mode;

  nsc_in_if  in_bus ();
  nsc_out_if out_bus ();

  nmea_sentence_checksum_framer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // character stream still to be sent, and words the framer owes us
  logic [7:0] char_queue [$];
  result_t    expected_words [$];

  int chars_sent;
  int total_chars;
  int mismatch_count;
  int quiet_cycles;

  // framer state as tracked by the bench
  logic [1:0]         fr_phase;
  logic [7:0]         fr_xor;
  logic [COUNT_W-1:0] fr_count;
  logic               fr_overflow;
  logic               fr_bad;

  logic [7:0] directed_chars [DIRECTED_LEN] = '{
    // noise outside any sentence
    8'h00, 8'hFF, CH_STAR, CH_0,
    // empty payload, checksum 00
    CH_DOLLAR, CH_STAR, CH_0, CH_0,
    // extreme bytes and a dollar inside the payload, checksum "dB"
    CH_DOLLAR, 8'h00, 8'hFF, CH_DOLLAR, CH_STAR, CH_LA + 8'd3, CH_UA + 8'd1,
    // empty payload, checksum "Ff" leaves residual FF
    CH_DOLLAR, CH_STAR, CH_UF, CH_LF,
    // non-hex high digit
    CH_DOLLAR, 8'h7F, CH_STAR, CH_LF + 8'd1, CH_9
  };

  // Decode one checksum character; non-hex gives zero and clears ok.
  function automatic logic [3:0] digit_value(input logic [7:0] c, output logic ok);
    ok = 1'b1;
    if (c inside {[CH_0:CH_9]}) return c[3:0];
    if (c inside {[CH_LA:CH_LF]} || c inside {[CH_UA:CH_UF]}) return c[3:0] + 4'd9;
    ok = 1'b0;
    return 4'd0;
  endfunction

  // Advance the tracked framer by one accepted character.
  task automatic frame_char(input logic [7:0] c);
    result_t    w;
    logic       ok;
    logic [3:0] nib;
    w = '0;
    case (fr_phase)
      PH_OUTSIDE: begin
        if (c == CH_DOLLAR) begin
          fr_xor      = '0;
          fr_count    = '0;
          fr_overflow = 1'b0;
          fr_bad      = 1'b0;
          fr_phase    = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (c == CH_STAR) begin
          fr_phase = PH_HIGH;
        end else begin
          fr_xor = fr_xor ^ c;
          // drop bytes past the limit but keep them in the checksum
          if (fr_count >= LEN_LIMIT) begin
            fr_overflow = 1'b1;
          end else begin
            fr_count = fr_count + 1'b1;
            w.data   = c;
            expected_words.push_back(w);
          end
        end
      end
      PH_HIGH: begin
        nib = digit_value(c, ok);
        if (!ok) fr_bad = 1'b1;
        fr_xor   = fr_xor ^ {nib, 4'h0};
        fr_phase = PH_LOW;
      end
      default: begin
        nib = digit_value(c, ok);
        if (!ok) fr_bad = 1'b1;
        fr_xor        = fr_xor ^ {4'h0, nib};
        fr_phase      = PH_OUTSIDE;
        w.is_end      = 1'b1;
        w.residual    = fr_xor;
        w.checksum_ok = (fr_xor == 8'h00) && !fr_bad && !fr_overflow;
        w.length      = fr_count;
        w.overflow    = fr_overflow;
        w.bad_hex     = fr_bad;
        expected_words.push_back(w);
      end
    endcase
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_0 + 8'(n);
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(n) - 8'd10;
  endfunction

  // Queue one sentence with random payload; mostly a good checksum.
  task automatic queue_sentence(input int plen, input bit long_form);
    logic [7:0] sum;
    logic [7:0] b;
    int         roll;
    sum = '0;
    if (!long_form && $urandom_range(0, 99) < 25) begin
      repeat ($urandom_range(1, 3)) char_queue.push_back(8'($urandom));
    end
    char_queue.push_back(CH_DOLLAR);
    for (int i = 0; i < plen; i++) begin
      b = 8'($urandom);
      // keep long payloads whole: no early star
      if (long_form && b == CH_STAR) b = b ^ 8'h01;
      sum = sum ^ b;
      char_queue.push_back(b);
    end
    char_queue.push_back(CH_STAR);
    roll = long_form ? 50 : $urandom_range(0, 99);
    if (roll < 3) return;  // truncated frame: the next characters become digits
    if (roll >= 85) begin
      char_queue.push_back(8'($urandom));
      char_queue.push_back(8'($urandom));
    end else begin
      if (roll >= 70) sum = sum ^ 8'($urandom_range(1, 255));
      char_queue.push_back(hex_char(sum[7:4]));
      char_queue.push_back(hex_char(sum[3:0]));
    end
  endtask

  function automatic string word_text(input result_t w);
    return $sformatf("end=%0d data=%h res=%h ok=%0d len=%0d ovf=%0d bad=%0d",
                     w.is_end, w.data, w.residual, w.checksum_ok, w.length,
                     w.overflow, w.bad_hex);
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // stimulus, reset and end of run
  initial begin
    rst_n          = 1'b0;
    draining       = 1'b0;
    idle_mode      = IDLE_NONE;
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = '0;
    out_bus.ready  = 1'b0;
    chars_sent     = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    fr_phase       = PH_OUTSIDE;
    fr_xor         = '0;
    fr_count       = '0;
    fr_overflow    = 1'b0;
    fr_bad         = 1'b0;

    foreach (directed_chars[i]) char_queue.push_back(directed_chars[i]);
    while (char_queue.size() < DIRECTED_LEN + 80) begin
      queue_sentence(($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                 : $urandom_range(0, 12), 1'b0);
    end
    // payload that reaches the limit and runs a few bytes past it
    queue_sentence(int'(LEN_LIMIT) + 3, 1'b1);
    total_chars = char_queue.size() + 80;
    while (char_queue.size() < total_chars) begin
      queue_sentence(($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                 : $urandom_range(0, 12), 1'b0);
    end
    total_chars = char_queue.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (chars_sent < total_chars) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    draining <= 1'b1;
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // driver: predict on acceptance, then offer the next character or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        frame_char(in_bus.rx_byte);
        chars_sent = chars_sent + 1;
      end
      if (chars_sent < DIRECTED_LEN || draining) begin
        idle_mode <= IDLE_NONE;
      end else begin
        idle_mode <= 2'(((chars_sent - DIRECTED_LEN) / SEGMENT_CHARS) % 4);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (char_queue.size() != 0 &&
            $urandom_range(0, 99) >= ((idle_mode == IDLE_SENDER) ? 66 :
                                      (idle_mode == IDLE_BOTH)   ? 17 : 0)) begin
          in_bus.rx_byte <= char_queue.pop_front();
          in_bus.valid   <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_words.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected word: %s", word_text({out_bus.is_end, out_bus.data,
              out_bus.residual, out_bus.checksum_ok, out_bus.length,
              out_bus.overflow, out_bus.bad_hex}));
          end
        end else begin
          if (expected_words[0].is_end      !== out_bus.is_end      ||
              expected_words[0].data        !== out_bus.data        ||
              expected_words[0].residual    !== out_bus.residual    ||
              expected_words[0].checksum_ok !== out_bus.checksum_ok ||
              expected_words[0].length      !== out_bus.length      ||
              expected_words[0].overflow    !== out_bus.overflow    ||
              expected_words[0].bad_hex     !== out_bus.bad_hex) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("word mismatch: expected %s", word_text(expected_words[0]));
              $display("               got      %s", word_text({out_bus.is_end,
                out_bus.data, out_bus.residual, out_bus.checksum_ok,
                out_bus.length, out_bus.overflow, out_bus.bad_hex}));
            end
          end
          void'(expected_words.pop_front());
        end
      end
      out_bus.ready <= draining ||
                       $urandom_range(0, 99) >= ((idle_mode == IDLE_RECV) ? 66 :
                                                 (idle_mode == IDLE_BOTH) ? 17 : 0);
    end
  end

  // watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
